// ----- src/bdil3_pkg.sv -----
package bdil3_pkg;

	// Row store depth; the widest frame the block can take.
	localparam int MAX_WIDTH = 1024;

	// Column counters and row store addresses.
	localparam int COL_W = $clog2(MAX_WIDTH);
	// Output row counter, as wide as the height register.
	localparam int HEIGHT_REG_W = 16;
	// The input row counter runs one row into the drain and one past it.
	localparam int ROW_W = HEIGHT_REG_W + 1;
	localparam int WIDTH_REG_W = 11;

	localparam int PIX_W = 8;
	localparam int WIN_COL_W = 3 * PIX_W;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = HEIGHT_REG_W;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// Reset values of the registers, kept as width - 1 and height - 1.
	localparam int WIDTH_RESET = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int WIDTH_M1_RESET = (WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET) - 1;
	localparam int HEIGHT_M1_RESET = HEIGHT_RESET - 1;

	// Item kinds on the input side.
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// Per-item decisions taken at acceptance and carried to the result stage.
	typedef struct packed {
		logic emit;
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic eor;
		logic eof;
	} bdil3_ctl_t;

endpackage

// ----- src/binary_dilation_3x3_unit.sv -----
// 3x3 binary dilation of a raster-scanned frame of 8-bit pixels.
// The input stream (s_*) carries one pixel per item in raster order; s_tuser
// marks an item as a frame pixel or as a drain item. Once the last pixel of
// the frame has been sent, width + 1 drain items push out the remaining
// results; drain items sent while the frame is still running are ignored.
// The output stream (m_*) carries one dilated pixel per item: the OR of the
// in-frame pixels of the 3x3 neighborhood, with m_tlast on the last pixel of
// a row and m_tuser on the last pixel of the frame. After that item the block
// waits for the first pixel of a new frame.
// A result belongs to the pixel one row and one pixel behind the item that
// releases it. m_tvalid rises once that item has passed two register stages:
// the input register with the row store read, then the window and the output
// register. An item can be accepted in every cycle while the output is not
// stalled; the rate is set by the single row store access per item, one read
// and one write per memory.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item, then s_tready drops until m_tready.
// Reset clears the counters, the window and both valid flags and sets the
// frame to 640 x 480; the row stores are not cleared and need no clearing
// pass. A write on the cfg port restarts the frame; write only while idle.
module binary_dilation_3x3_unit
	import bdil3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic [0:0]            s_tuser,   // [0] kind: 0 frame pixel, 1 drain item

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [PIX_W-1:0]      m_tdata,   // [7:0] out_pixel
	output logic                  m_tlast,   // end_of_row
	output logic [0:0]            m_tuser,   // [0] end_of_frame

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Frame size, held as width - 1 and height - 1 after clamping.
	logic [COL_W-1:0]        wm1_q;
	logic [HEIGHT_REG_W-1:0] hm1_q;

	// Input and output position counters.
	logic [COL_W-1:0]        icol_q;
	logic [ROW_W-1:0]        irow_q;
	logic [COL_W-1:0]        ocol_q;
	logic [HEIGHT_REG_W-1:0] orow_q;

	// Row stores: near holds the previous row, far the row before it.
	logic [PIX_W-1:0] row_near_q [MAX_WIDTH];
	logic [PIX_W-1:0] row_far_q  [MAX_WIDTH];

	// Input stage.
	logic              valid_s1;
	bdil3_ctl_t        ctl_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [PIX_W-1:0]  near_rd_s1;
	logic [PIX_W-1:0]  far_rd_s1;

	// Window: left and center columns; the right column is the one arriving.
	logic [WIN_COL_W-1:0] win_l_q;
	logic [WIN_COL_W-1:0] win_c_q;

	// Output register.
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_pix_q;
	logic              out_eor_q;
	logic              out_eof_q;

	logic              accept;
	logic              advance;
	logic              draining;
	logic              counts;
	logic              col0;
	logic              icol_last;
	logic [PIX_W-1:0]  pix_d;
	bdil3_ctl_t        ctl_d;
	logic [WIN_COL_W-1:0] col_new;
	logic [PIX_W-1:0]  dil_pix;

	function automatic logic [COL_W-1:0] width_m1(input logic [WIDTH_REG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (32'(v) > 32'(MAX_WIDTH)) begin
			r = COL_W'(MAX_WIDTH - 1);
		end else if (v < WIDTH_REG_W'(2)) begin
			r = COL_W'(1);
		end else begin
			r = COL_W'(v - WIDTH_REG_W'(1));
		end
		return r;
	endfunction

	function automatic logic [HEIGHT_REG_W-1:0] height_m1(input logic [HEIGHT_REG_W-1:0] v);
		logic [HEIGHT_REG_W-1:0] r;
		if (v < HEIGHT_REG_W'(2)) begin
			r = HEIGHT_REG_W'(1);
		end else begin
			r = v - HEIGHT_REG_W'(1);
		end
		return r;
	endfunction

	// OR of the rows of one window column that lie inside the frame.
	function automatic logic [PIX_W-1:0] column_or(input logic [WIN_COL_W-1:0] col,
	                                               input logic top, input logic bottom);
		logic [PIX_W-1:0] v;
		v = col[2*PIX_W-1:PIX_W];
		if (top) v = v | col[PIX_W-1:0];
		if (bottom) v = v | col[3*PIX_W-1:2*PIX_W];
		return v;
	endfunction

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= COL_W'(WIDTH_M1_RESET);
			hm1_q <= HEIGHT_REG_W'(HEIGHT_M1_RESET);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:  wm1_q <= width_m1(cfg_data[WIDTH_REG_W-1:0]);
				REG_IMAGE_HEIGHT: hm1_q <= height_m1(cfg_data);
				default:          ;
			endcase
		end
	end

	// Everything that decides whether and where a result appears depends only
	// on the counters, so it is settled when the item is accepted.
	always_comb begin
		draining   = irow_q > {1'b0, hm1_q};
		counts     = !(s_tuser[0] == KIND_DRAIN && !draining);
		pix_d      = draining ? '0 : s_tdata;
		col0       = icol_q == '0;
		icol_last  = icol_q >= wm1_q;
		// At the start of a row the last pixel of the row two rows back comes
		// out; otherwise the pixel one row up and one column left does.
		ctl_d.emit   = col0 ? (irow_q >= ROW_W'(2)) : (irow_q != '0);
		ctl_d.eor    = ocol_q >= wm1_q;
		ctl_d.eof    = ctl_d.eor && (orow_q >= hm1_q);
		ctl_d.top    = orow_q != '0;
		ctl_d.bottom = orow_q < hm1_q;
		ctl_d.left   = ocol_q != '0;
		ctl_d.right  = !ctl_d.eor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (cfg_we) begin
			icol_q <= '0;
			irow_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (accept && counts) begin
			if (ctl_d.emit) begin
				if (ctl_d.eof) begin
					ocol_q <= '0;
					orow_q <= '0;
				end else if (ctl_d.eor) begin
					ocol_q <= '0;
					orow_q <= orow_q + HEIGHT_REG_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end
			// The item that ends the frame leaves the input side at the start.
			if (ctl_d.emit && ctl_d.eof) begin
				icol_q <= '0;
				irow_q <= '0;
			end else if (icol_last) begin
				icol_q <= '0;
				irow_q <= irow_q + ROW_W'(1);
			end else begin
				icol_q <= icol_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctl_s1   <= '0;
		end else if (accept) begin
			valid_s1 <= counts;
			ctl_s1   <= ctl_d;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && counts) begin
			pix_s1  <= pix_d;
			addr_s1 <= icol_q;
		end
	end

	// Near store: read and written at the input column as the item enters.
	always_ff @(posedge clk) begin
		if (accept && counts) begin
			near_rd_s1         <= row_near_q[icol_q];
			row_near_q[icol_q] <= pix_d;
			far_rd_s1          <= row_far_q[icol_q];
		end
	end

	// Far store: takes the old near value as the item leaves the input stage.
	// Only right after a frame restart can this write and the next read hit the
	// same column, and that read feeds a row above the new frame, which is masked.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			row_far_q[addr_s1] <= near_rd_s1;
		end
	end

	always_comb begin
		col_new = {pix_s1, near_rd_s1, far_rd_s1};
		dil_pix = column_or(win_c_q, ctl_s1.top, ctl_s1.bottom);
		if (ctl_s1.left) dil_pix = dil_pix | column_or(win_l_q, ctl_s1.top, ctl_s1.bottom);
		if (ctl_s1.right) dil_pix = dil_pix | column_or(col_new, ctl_s1.top, ctl_s1.bottom);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_l_q     <= '0;
			win_c_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && ctl_s1.emit;
			if (valid_s1) begin
				win_l_q <= win_c_q;
				win_c_q <= col_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && ctl_s1.emit) begin
			out_pix_q <= dil_pix;
			out_eor_q <= ctl_s1.eor;
			out_eof_q <= ctl_s1.eof;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_pix_q;
	assign m_tlast    = out_eor_q;
	assign m_tuser[0] = out_eof_q;

	a_eof_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("end of frame without end of row");

	a_icol_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		icol_q <= wm1_q)
		else $error("input column beyond frame width");

	a_ocol_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		ocol_q <= wm1_q)
		else $error("output column beyond frame width");

	a_orow_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		orow_q <= hm1_q)
		else $error("output row beyond frame height");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && ctl_s1.emit))
		else $error("result appeared without an emitting item");

endmodule

// ----- tb/sv/dilation_checker.sv -----
`timescale 1ns / 1ps

module dilation_checker
	import bdil3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic [0:0]            s_tuser,   // [0] kind

	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [PIX_W-1:0]      m_tdata,   // [7:0] out_pixel
	input  logic                  m_tlast,   // end_of_row
	input  logic [0:0]            m_tuser,   // [0] end_of_frame

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	output int                    fail_count,
	output int                    open_results
);

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             eor;
		logic             eof;
	} dilated_pixel_t;

	dilated_pixel_t expected_pixels[$];
	dilated_pixel_t oldest;

	// Shadow of the two row stores and the three window columns.
	// A column holds the row two back in [7:0], one back in [15:8], current in [23:16].
	logic [PIX_W-1:0]     near_row [MAX_WIDTH];
	logic [PIX_W-1:0]     far_row [MAX_WIDTH];
	logic [WIN_COL_W-1:0] win [3];

	int width_reg, height_reg;
	int in_col, in_row, out_col, out_row;
	int fails;

	function automatic int frame_width();
		if (width_reg < 2) return 2;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int frame_height();
		return (height_reg < 2) ? 2 : height_reg;
	endfunction

	function automatic void restart_frame();
		win[0] = '0;
		win[1] = '0;
		win[2] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	function automatic logic [PIX_W-1:0] column_or(logic [WIN_COL_W-1:0] c, bit top, bit bottom);
		logic [PIX_W-1:0] v;
		v = c[15:8];
		if (top) v |= c[7:0];
		if (bottom) v |= c[23:16];
		return v;
	endfunction

	// Queues the dilated pixel at the output position and moves that position on.
	// Returns 1 when the pixel closes the frame.
	function automatic bit push_dilated(logic [WIN_COL_W-1:0] lft, logic [WIN_COL_W-1:0] ctr,
			logic [WIN_COL_W-1:0] rgt);
		int w, h;
		bit top, bottom;
		dilated_pixel_t r;
		w = frame_width();
		h = frame_height();
		top = out_row > 0;
		bottom = out_row < h - 1;
		r.eor = out_col >= w - 1;
		r.eof = r.eor && out_row >= h - 1;
		r.pix = column_or(ctr, top, bottom);
		if (out_col > 0) r.pix |= column_or(lft, top, bottom);
		if (!r.eor) r.pix |= column_or(rgt, top, bottom);
		expected_pixels.push_back(r);
		if (r.eof) begin
			restart_frame();
		end else if (r.eor) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return r.eof;
	endfunction

	function automatic void predict_dilation(logic kind, logic [PIX_W-1:0] pix);
		int w, h, ic, ir;
		bit draining, emitted, closed;
		logic [PIX_W-1:0] p;
		logic [WIN_COL_W-1:0] col;
		w = frame_width();
		h = frame_height();
		draining = in_row >= h;
		// A drain item inside the frame leaves everything as it was.
		if (kind == KIND_DRAIN && !draining) return;
		p = draining ? '0 : pix;
		ic = (in_col >= w) ? 0 : in_col;
		ir = in_row;
		emitted = 0;
		closed = 0;
		// At the start of a row the last pixel of the row two back comes out
		// from the window as it stood before the shift.
		if (ic == 0 && ir >= 2) begin
			closed = push_dilated(win[1], win[2], '0);
			emitted = 1;
		end
		col = {p, near_row[ic], far_row[ic]};
		far_row[ic] = near_row[ic];
		near_row[ic] = p;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = col;
		if (!emitted && ic >= 1 && ir >= 1) begin
			closed = push_dilated(win[0], win[1], win[2]);
		end
		if (!closed) begin
			ic++;
			if (ic >= w) begin
				ic = 0;
				ir++;
			end
			in_col = ic;
			in_row = ir;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (near_row[i]) begin
				near_row[i] = '0;
				far_row[i] = '0;
			end
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			restart_frame();
			expected_pixels.delete();
			fails = 0;
			fail_count <= 0;
			open_results <= 0;
		end else begin
			// Results leave only after their item has passed both register stages, so check before predicting.
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					fails++;
					$display("%0t: expected no item, actual pixel %02h eor %0b eof %0b",
						$time, m_tdata, m_tlast, m_tuser[0]);
				end else begin
					oldest = expected_pixels.pop_front();
					if (m_tdata !== oldest.pix) begin
						fails++;
						$display("%0t: out_pixel expected %02h, actual %02h",
							$time, oldest.pix, m_tdata);
					end
					if (m_tlast !== oldest.eor) begin
						fails++;
						$display("%0t: end_of_row expected %0b, actual %0b",
							$time, oldest.eor, m_tlast);
					end
					if (m_tuser[0] !== oldest.eof) begin
						fails++;
						$display("%0t: end_of_frame expected %0b, actual %0b",
							$time, oldest.eof, m_tuser[0]);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_addr == REG_IMAGE_WIDTH) width_reg = int'(cfg_data[WIDTH_REG_W-1:0]);
				else if (cfg_addr == REG_IMAGE_HEIGHT) height_reg = int'(cfg_data);
				restart_frame();
			end
			if (s_tvalid && s_tready) predict_dilation(s_tuser[0], s_tdata);
			fail_count <= fails;
			open_results <= expected_pixels.size();
		end
	end

endmodule

// ----- tb/sv/tb_binary_dilation_3x3_unit.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the 3x3 dilation unit. The checker beside the
// block sees every accepted item on both streams and every register write;
// this module only creates traffic and decides pass or fail at the end.
module tb_binary_dilation_3x3_unit;
	import bdil3_pkg::*;

	// Generous bound on the whole run; the slowest legal run needs far less.
	localparam int CYCLE_LIMIT = 600000;
	// Cycles the block may still be busy after its last result has left.
	localparam int SETTLE_CYCLES = 4;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata = '0;   // [7:0] pixel
	logic [0:0]            s_tuser = '0;   // [0] kind

	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [PIX_W-1:0]      m_tdata;        // [7:0] out_pixel
	logic                  m_tlast;        // end_of_row
	logic [0:0]            m_tuser;        // [0] end_of_frame

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int open_results;
	int cycles = 0;

	// Chance, in percent, that the sender idles before an item and that the
	// receiver holds off in a given cycle.
	int idle_pct = 0;
	int stall_pct = 0;

	// Frame size as the block will use it, after clamping of the registers.
	int cur_w = WIDTH_RESET;
	int cur_h = HEIGHT_RESET;

	binary_dilation_3x3_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	dilation_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.open_results (open_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver draws a fresh ready every cycle according to the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: a hung handshake or a missing result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Phase 0 runs flat out, 1 idles the sender, 2 stalls the receiver and 3
	// does a little of both.
	task automatic set_pressure(int phase);
		case (phase)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 66;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 66;
			end
			default: begin
				idle_pct = 15;
				stall_pct = 15;
			end
		endcase
	endtask

	// Offers one item and returns at the edge that accepts it. Valid stays high
	// into the next call, so back-to-back items need no bubble; an idle gap
	// lowers it first.
	task automatic send_item(logic kind, logic [PIX_W-1:0] pix);
		int gap;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser[0] <= kind;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops sending and waits until every predicted result has been taken,
	// then lets the pipeline run empty before anything else happens.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The enable goes low again once the write has been taken, so two writes never share a step.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Writes both registers, which also restarts the frame in the block.
	task automatic set_frame(int wr, int hr);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wr));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hr));
		cur_w = (wr < 2) ? 2 : ((wr > MAX_WIDTH) ? MAX_WIDTH : wr);
		cur_h = (hr < 2) ? 2 : hr;
	endtask

	// One frame of random size and content. Most frames are complete with the
	// drain that flushes them; a few stop early and are cut off by the next
	// register write. Counts the items that matter to the block.
	task automatic random_frame(output int sent);
		int wr, hr, r, density, n_px, n_drain, n_extra;
		bit binary, broken;
		r = $urandom_range(99);
		if (r < 70) wr = $urandom_range(2, 8);
		else if (r < 92) wr = $urandom_range(9, 40);
		else wr = $urandom_range(0, 1);
		r = $urandom_range(99);
		if (r < 75) hr = $urandom_range(2, 6);
		else if (r < 93) hr = $urandom_range(7, 12);
		else hr = $urandom_range(0, 1);
		set_frame(wr, hr);
		binary = ($urandom_range(3) != 0);
		density = $urandom_range(5, 60);
		broken = ($urandom_range(99) < 8);
		n_px = broken ? $urandom_range(1, cur_w * cur_h - 1) : cur_w * cur_h;
		n_drain = cur_w + 1;
		n_extra = $urandom_range(2);
		sent = 0;
		for (int i = 0; i < n_px; i++) begin
			// Now and then a drain item inside the frame, which must be ignored.
			if ($urandom_range(99) < 4) send_item(KIND_DRAIN, 8'($urandom_range(255)));
			if (binary)
				send_item(KIND_PIXEL, ($urandom_range(99) < density) ? 8'hFF : 8'h00);
			else
				send_item(KIND_PIXEL, 8'($urandom_range(255)));
			sent++;
		end
		if (!broken) begin
			// Past the last pixel a frame pixel counts as a drain item too.
			for (int i = 0; i < n_drain; i++) begin
				send_item($urandom_range(1) ? KIND_DRAIN : KIND_PIXEL, 8'($urandom_range(255)));
				sent++;
			end
			// After end of frame further drain items produce nothing.
			for (int i = 0; i < n_extra; i++) send_item(KIND_DRAIN, 8'($urandom_range(255)));
		end
		settle();
	endtask

	initial begin
		logic [PIX_W-1:0] single_dot [9];
		int total, sent, frame_no;

		single_dot = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame: extreme values, an ignored drain item inside the
		// frame, a pixel after the last pixel, and surplus drain items.
		set_pressure(0);
		set_frame(2, 2);
		send_item(KIND_PIXEL, 8'h00);
		send_item(KIND_DRAIN, 8'hFF);
		send_item(KIND_PIXEL, 8'hFF);
		send_item(KIND_PIXEL, 8'hAA);
		send_item(KIND_PIXEL, 8'h55);
		send_item(KIND_PIXEL, 8'h81);
		send_item(KIND_DRAIN, 8'h00);
		send_item(KIND_DRAIN, 8'h00);
		send_item(KIND_DRAIN, 8'hFF);
		send_item(KIND_DRAIN, 8'hFF);
		settle();

		// Width zero and height one both clamp to two.
		set_frame(0, 1);
		send_item(KIND_PIXEL, 8'h01);
		send_item(KIND_PIXEL, 8'h80);
		send_item(KIND_PIXEL, 8'h7E);
		send_item(KIND_PIXEL, 8'h00);
		repeat (3) send_item(KIND_DRAIN, 8'h00);
		settle();

		// One set pixel in the middle must grow to fill the whole 3 x 3 frame.
		set_frame(3, 3);
		foreach (single_dot[i]) send_item(KIND_PIXEL, single_dot[i]);
		repeat (4) send_item(KIND_DRAIN, 8'h00);
		settle();

		// Tallest frame: only its first rows are sent, then a write cuts it off.
		set_frame(3, 65535);
		for (int i = 0; i < 40; i++) send_item(KIND_PIXEL, 8'($urandom_range(255)));
		settle();

		// Random frames, rotating through the idle and stall phases; with the
		// frames above this makes at least 550 items in all.
		total = 0;
		frame_no = 0;
		while (total < 480) begin
			set_pressure(frame_no % 4);
			random_frame(sent);
			total += sent;
			frame_no++;
		end

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && open_results == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
